// ----- sv/assembly_source_tokenizer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assembly source tokenizer assertion macros
// Clocked assertion helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define ASMTOK_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("asmtok assertion failed");

// condition that must never hold outside reset
`define ASMTOK_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("asmtok forbidden condition");

`else

`define ASMTOK_ASSERT(label, prop)
`define ASMTOK_NEVER(label, cond)

`endif

`endif

// ----- sv/asmtok_pkg.sv -----
// ----------------------------------------------------------------------------
// Assembly source tokenizer package
// Sizes, character codes, state and event types shared by the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asmtok_pkg;

  // line buffer and token limits
  localparam int unsigned BUFFER_BYTES    = 1024;
  localparam int unsigned MAX_LINE_TOKENS = 8;
  localparam int unsigned FILL_W          = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned TOK_W           = $clog2(MAX_LINE_TOKENS + 1);

  // event group queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // events produced by one item at most
  localparam int unsigned EV_MAX = 3;
  localparam int unsigned EVI_W  = $clog2(EV_MAX);

  // output field widths
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned TOTAL_W  = 4;
  localparam int unsigned LINE_W   = 20;

  // character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // error codes
  localparam logic [7:0] ERR_OVERFLOW = 8'd0;
  localparam logic [7:0] ERR_TOKENS   = 8'd1;
  localparam logic [7:0] ERR_SLASH    = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_GAP,
    ST_LABEL,
    ST_EQ,
    ST_ARG,
    ST_COMMA,
    ST_SLASH,
    ST_REMARK,
    ST_QUOTE,
    ST_BACKSL,
    ST_DONE
  } lex_state_e;

  typedef enum logic [1:0] {
    EV_BYTE,
    EV_TOKEN,
    EV_LINE,
    EV_ERROR
  } event_kind_e;

  typedef enum logic [1:0] {
    LK_INSTR,
    LK_LABEL,
    LK_DEFINE
  } line_kind_e;

  typedef struct packed {
    event_kind_e           kind;
    logic [7:0]            value;
    logic [OFFSET_W-1:0]   offset;
    logic [TOTAL_W-1:0]    total;
    line_kind_e            lkind;
  } event_t;

  // all events caused by one item
  typedef struct packed {
    logic [1:0]            cnt;
    event_t [EV_MAX-1:0]   ev;
    logic [LINE_W-1:0]     line_cnt;
  } group_t;

endpackage

// ----- sv/asmtok_front.sv -----
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, runs the lexer state machine and builds the group of
// events that each byte causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assembly_source_tokenizer_top_defines.svh"

module asmtok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  input  logic                end_of_input_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output asmtok_pkg::group_t  q_data_o
);
  import asmtok_pkg::*;

  lex_state_e              state_q, state_d, lex_next;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [TOK_W-1:0]        tc_q, tc_d;
  line_kind_e              pend_q, pend_d;
  logic [LINE_W-1:0]       nl_q, nl_d;
  logic                    err_q, err_d;

  logic                    accept;
  logic                    active;
  logic                    is_sp;
  logic                    do_err2, do_tok, do_push, do_line, set_def;
  logic [7:0]              push_byte;
  line_kind_e              line_kind;
  logic                    buf_full, line_full, any_err;
  event_t [3:0]            cand;
  logic [3:0]              cand_v;
  group_t                  grp;
  logic [1:0]              n;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign active     = (state_q != ST_DONE);
  assign is_sp      = (char_code_i == CH_SPACE) || (char_code_i == CH_TAB) ||
                      (char_code_i == CH_LF) || (char_code_i == CH_CR);

  // lexer next state
  always_comb begin
    lex_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (char_code_i == CH_SLASH) lex_next = ST_SLASH;
        else if (!is_sp && char_code_i != CH_SEMI) lex_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (is_sp) lex_next = ST_GAP;
        else if (char_code_i == CH_EQUAL) lex_next = ST_EQ;
        else if (char_code_i == CH_COLON) lex_next = ST_LABEL;
      end
      ST_GAP: begin
        if (char_code_i == CH_EQUAL) lex_next = ST_EQ;
        else if (char_code_i == CH_QUOTE) lex_next = ST_QUOTE;
        else if (!is_sp) lex_next = ST_ARG;
      end
      ST_LABEL: begin
        if (char_code_i == CH_SLASH) lex_next = ST_SLASH;
        else if (!is_sp) lex_next = ST_HEAD;
        else lex_next = ST_IDLE;
      end
      ST_EQ, ST_COMMA: begin
        if (!is_sp) lex_next = ST_ARG;
      end
      ST_ARG: begin
        if (char_code_i == CH_SEMI || is_sp) lex_next = ST_IDLE;
        else if (char_code_i == CH_COMMA) lex_next = ST_COMMA;
      end
      ST_SLASH: begin
        if (char_code_i == CH_SLASH) lex_next = ST_REMARK;
        else lex_next = ST_IDLE;
      end
      ST_REMARK: begin
        if (char_code_i == CH_LF) lex_next = ST_IDLE;
      end
      ST_QUOTE: begin
        if (char_code_i == CH_BSLASH) lex_next = ST_BACKSL;
        else if (char_code_i == CH_QUOTE) lex_next = ST_IDLE;
      end
      ST_BACKSL: begin
        lex_next = ST_QUOTE;
      end
      default: begin
        lex_next = state_q;
      end
    endcase

    state_d = state_q;
    if (accept && active) begin
      state_d = end_of_input_i ? ST_DONE : lex_next;
    end
  end

  // actions taken on entering the next state
  always_comb begin
    do_err2   = 1'b0;
    do_tok    = 1'b0;
    do_push   = 1'b0;
    do_line   = 1'b0;
    set_def   = 1'b0;
    push_byte = CH_NUL;
    line_kind = (pend_q == LK_DEFINE) ? LK_DEFINE : LK_INSTR;
    if (active) begin
      if (end_of_input_i) begin
        if (state_q != ST_IDLE) begin
          do_err2 = (state_q == ST_SLASH);
          if (fill_q != '0) begin
            do_push = 1'b1;
            do_line = 1'b1;
          end
        end
      end else begin
        do_err2 = (state_q == ST_SLASH) && (char_code_i != CH_SLASH);
        case (lex_next)
          ST_IDLE: begin
            if (fill_q != '0) begin
              do_push = 1'b1;
              do_line = 1'b1;
            end
          end
          ST_HEAD, ST_ARG: begin
            do_tok    = (state_q != lex_next);
            do_push   = 1'b1;
            push_byte = char_code_i;
          end
          ST_GAP: begin
            do_push = 1'b1;
          end
          ST_LABEL: begin
            do_push   = 1'b1;
            do_line   = 1'b1;
            line_kind = LK_LABEL;
          end
          ST_EQ: begin
            do_push = 1'b1;
            set_def = 1'b1;
          end
          ST_COMMA: begin
            do_push = (state_q != ST_COMMA);
          end
          ST_QUOTE: begin
            if (state_q == ST_BACKSL) begin
              // escape sequences, unknown ones write nothing
              case (char_code_i)
                CH_QUOTE: begin
                  do_push   = 1'b1;
                  push_byte = CH_QUOTE;
                end
                CH_BSLASH: begin
                  do_push   = 1'b1;
                  push_byte = CH_BSLASH;
                end
                CH_LOW_N: begin
                  do_push   = 1'b1;
                  push_byte = CH_LF;
                end
                CH_LOW_T: begin
                  do_push   = 1'b1;
                  push_byte = CH_TAB;
                end
                default: begin
                  do_push = 1'b0;
                end
              endcase
            end else if (state_q != ST_QUOTE) begin
              do_tok = 1'b1;
            end else begin
              do_push   = 1'b1;
              push_byte = char_code_i;
            end
          end
          default: begin
            do_push = 1'b0;
          end
        endcase
      end
    end
  end

  // candidate events in their fixed order
  assign buf_full  = (fill_q >= FILL_W'(BUFFER_BYTES));
  assign line_full = (tc_q >= TOK_W'(MAX_LINE_TOKENS));
  assign any_err   = do_err2 || (do_tok && line_full) || (do_push && buf_full);
  assign cand_v    = {do_line, do_push, do_tok, do_err2};

  always_comb begin
    cand = '0;
    cand[0].kind  = EV_ERROR;
    cand[0].value = ERR_SLASH;
    if (line_full) begin
      cand[1].kind  = EV_ERROR;
      cand[1].value = ERR_TOKENS;
    end else begin
      cand[1].kind   = EV_TOKEN;
      cand[1].offset = OFFSET_W'(fill_q);
    end
    if (buf_full) begin
      cand[2].kind  = EV_ERROR;
      cand[2].value = ERR_OVERFLOW;
    end else begin
      cand[2].kind  = EV_BYTE;
      cand[2].value = push_byte;
    end
    cand[3].kind  = EV_LINE;
    cand[3].total = TOTAL_W'(tc_q);
    cand[3].lkind = line_kind;
  end

  // line counter, saturating
  always_comb begin
    nl_d = nl_q;
    if (accept && active && !end_of_input_i && char_code_i == CH_LF && nl_q != '1) begin
      nl_d = nl_q + LINE_W'(1);
    end
  end

  // pack the present events into one group
  always_comb begin
    grp = '0;
    n   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        grp.ev[n[EVI_W-1:0]] = cand[i];
        n = n + 2'd1;
      end
    end
    grp.cnt      = n;
    grp.line_cnt = nl_d;
  end

  assign q_push_o = accept && (n != 2'd0);
  assign q_data_o = grp;

  // buffer fill, token count, pending kind and error flag
  always_comb begin
    fill_d = fill_q;
    tc_d   = tc_q;
    pend_d = pend_q;
    err_d  = err_q;
    if (accept) begin
      if (do_line) begin
        fill_d = '0;
        tc_d   = '0;
        pend_d = LK_INSTR;
      end else begin
        if (do_push && !buf_full) fill_d = fill_q + FILL_W'(1);
        if (do_tok && !line_full) tc_d = tc_q + TOK_W'(1);
        if (set_def) pend_d = LK_DEFINE;
      end
      if (any_err) err_d = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      tc_q    <= '0;
      pend_q  <= LK_INSTR;
      nl_q    <= LINE_W'(1);
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      tc_q    <= tc_d;
      pend_q  <= pend_d;
      nl_q    <= nl_d;
      err_q   <= err_d;
    end
  end

  // checks
  `ASMTOK_ASSERT(a_err_sticky, (accept && any_err) |=> err_q)
  `ASMTOK_ASSERT(a_done_holds, (state_q == ST_DONE) |=> (state_q == ST_DONE))
  `ASMTOK_NEVER(a_fill_range, fill_q > FILL_W'(BUFFER_BYTES))

endmodule

// ----- sv/asmtok_queue.sv -----
// ----------------------------------------------------------------------------
// Tokenizer event group queue
// Short register queue of event groups between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assembly_source_tokenizer_top_defines.svh"

module asmtok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  asmtok_pkg::group_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output asmtok_pkg::group_t  data_o,
  output logic                valid_o
);
  import asmtok_pkg::*;

  group_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W:0]     wr_q, wr_d, rd_q, rd_d;

  assign full_o  = (wr_q[QPTR_W] != rd_q[QPTR_W]) &&
                   (wr_q[QPTR_W-1:0] == rd_q[QPTR_W-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign data_o  = mem_q[rd_q[QPTR_W-1:0]];

  // pointer update
  always_comb begin
    wr_d = push_i ? wr_q + (QPTR_W+1)'(1) : wr_q;
    rd_d = pop_i ? rd_q + (QPTR_W+1)'(1) : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QPTR_W-1:0]] <= data_i;
    end
  end

  // checks
  `ASMTOK_NEVER(a_no_overrun, push_i && full_o)
  `ASMTOK_NEVER(a_no_underrun, pop_i && !valid_o)

endmodule

// ----- sv/asmtok_back.sv -----
// ----------------------------------------------------------------------------
// Tokenizer back end
// Walks each queued event group and presents one event per cycle, while the
// output is not stalled, in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assembly_source_tokenizer_top_defines.svh"

module asmtok_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asmtok_pkg::group_t  grp_i,
  input  logic                grp_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          event_kind_o,
  output logic [7:0]          event_value_o,
  output logic [9:0]          token_offset_o,
  output logic [3:0]          token_total_o,
  output logic [1:0]          line_kind_o,
  output logic [19:0]         line_cnt_o,
  output logic                last_of_run_o
);
  import asmtok_pkg::*;

  logic [EVI_W-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  event_t              ev_q;
  logic [LINE_W-1:0]   line_q;
  logic                last_q;
  logic                load;
  logic                last;

  // take the next event when the output register is free or drains
  assign load  = grp_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (idx_q == EVI_W'(grp_i.cnt - 2'd1));
  assign pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + EVI_W'(1);
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q   <= grp_i.ev[idx_q];
      line_q <= grp_i.line_cnt;
      last_q <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = ev_q.kind;
  assign event_value_o  = ev_q.value;
  assign token_offset_o = ev_q.offset;
  assign token_total_o  = ev_q.total;
  assign line_kind_o    = ev_q.lkind;
  assign line_cnt_o     = line_q;
  assign last_of_run_o  = last_q;

  // checks
  `ASMTOK_ASSERT(a_pop_marks_last, pop_o |=> last_q)
  `ASMTOK_ASSERT(a_idx_in_group, grp_valid_i |-> (idx_q < EVI_W'(grp_i.cnt)))

endmodule

// ----- sv/assembly_source_tokenizer_top.sv -----
// Flow: an accepted item is written into the event group queue, and its first
// event is then loaded into the output register; further events of the item
// follow one a cycle while the output is not stalled. Throughput: one item per
// cycle unless the queue is full; a four-group queue between lexer and output
// register absorbs event bursts. Reset: asynchronous, active low; lexer idle,
// empty line, line count one, queue and output register empty. No clearing pass.
// ----------------------------------------------------------------------------
// Assembly source tokenizer top level
// Character lexer for assembly source: front end lexer, event group queue
// and back end event serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module assembly_source_tokenizer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   char_code_i,
  input  logic         end_of_input_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   event_kind_o,
  output logic [7:0]   event_value_o,
  output logic [9:0]   token_offset_o,
  output logic [3:0]   token_total_o,
  output logic [1:0]   line_kind_o,
  output logic [19:0]  line_cnt_o,
  output logic         last_of_run_o
);
  import asmtok_pkg::*;

  logic    q_push, q_full, q_pop, q_valid;
  group_t  q_wdata, q_rdata;

  // lexer
  asmtok_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  // event group queue
  asmtok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .valid_o (q_valid)
  );

  // event serializer
  asmtok_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grp_i          (q_rdata),
    .grp_valid_i    (q_valid),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .event_value_o  (event_value_o),
    .token_offset_o (token_offset_o),
    .token_total_o  (token_total_o),
    .line_kind_o    (line_kind_o),
    .line_cnt_o     (line_cnt_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ----- verif/asmtok_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assembly source tokenizer event checker
// Watches the byte and event channels of the tokenizer, runs its own lexer
// model on every accepted source byte and compares each accepted event, field
// by field, with the oldest predicted one. Failures are counted for the top.
// ----------------------------------------------------------------------------

module asmtok_event_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      char_code_i,
  input  logic                            end_of_input_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [1:0]                      event_kind_i,
  input  logic [7:0]                      event_value_i,
  input  logic [asmtok_pkg::OFFSET_W-1:0] token_offset_i,
  input  logic [asmtok_pkg::TOTAL_W-1:0]  token_total_i,
  input  logic [1:0]                      line_kind_i,
  input  logic [asmtok_pkg::LINE_W-1:0]   line_cnt_i,
  input  logic                            last_of_run_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              events_o,
  output int                              errors_o
);
  import asmtok_pkg::*;

  typedef struct packed {
    event_t            ev;
    logic [LINE_W-1:0] line;
    logic              last;
  } lex_event_t;

  // predicted events, oldest first, and those of the byte being modeled
  lex_event_t events_due[$];
  lex_event_t byte_events[$];

  // lexer model state
  lex_state_e        lex_state;
  logic [FILL_W-1:0] fill;
  logic [TOK_W-1:0]  tokens;
  line_kind_e        pend_kind;
  logic [LINE_W-1:0] line_count;

  int fails;
  int seen;
  int lex_errors;

  task automatic add_event(input event_kind_e kind, input logic [7:0] value,
                           input logic [OFFSET_W-1:0] offset,
                           input logic [TOTAL_W-1:0] total, input line_kind_e lkind);
    lex_event_t e;
    e.ev.kind   = kind;
    e.ev.value  = value;
    e.ev.offset = offset;
    e.ev.total  = total;
    e.ev.lkind  = lkind;
    e.line      = line_count;
    e.last      = 1'b0;
    if (byte_events.size() < EV_MAX) byte_events.push_back(e);
  endtask

  task automatic raise_error(input logic [7:0] code);
    add_event(EV_ERROR, code, '0, '0, LK_INSTR);
  endtask

  // buffer write, or overflow error once the line buffer is full
  task automatic push_char(input logic [7:0] b);
    if (fill >= BUFFER_BYTES) begin
      raise_error(ERR_OVERFLOW);
    end else begin
      fill++;
      add_event(EV_BYTE, b, '0, '0, LK_INSTR);
    end
  endtask

  task automatic open_token();
    if (tokens >= MAX_LINE_TOKENS) begin
      raise_error(ERR_TOKENS);
    end else begin
      add_event(EV_TOKEN, 8'd0, fill[OFFSET_W-1:0], '0, LK_INSTR);
      tokens++;
    end
  endtask

  task automatic close_line(input line_kind_e lkind);
    fill = '0;
    add_event(EV_LINE, 8'd0, '0, tokens, lkind);
    tokens    = '0;
    pend_kind = LK_INSTR;
  endtask

  // a pending line is closed with a separator; a define stays a define
  task automatic flush_line();
    if (fill != 0) begin
      push_char(CH_NUL);
      close_line(pend_kind == LK_DEFINE ? LK_DEFINE : LK_INSTR);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic fin);
    lex_state_e prev;
    lex_state_e nxt;
    logic       blank;
    if (lex_state == ST_DONE) return;
    byte_events.delete();
    prev = lex_state;
    nxt  = prev;
    if (fin) begin
      if (prev != ST_IDLE) begin
        if (prev == ST_SLASH) raise_error(ERR_SLASH);
        flush_line();
      end
      lex_state = ST_DONE;
    end else begin
      if (c == CH_LF && line_count != {LINE_W{1'b1}}) line_count++;
      blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);

      // next lexer state
      case (prev)
        ST_IDLE: begin
          if (c == CH_SLASH) nxt = ST_SLASH;
          else if (!blank && c != CH_SEMI) nxt = ST_HEAD;
        end
        ST_HEAD: begin
          if (blank) nxt = ST_GAP;
          else if (c == CH_EQUAL) nxt = ST_EQ;
          else if (c == CH_COLON) nxt = ST_LABEL;
        end
        ST_GAP: begin
          if (c == CH_EQUAL) nxt = ST_EQ;
          else if (c == CH_QUOTE) nxt = ST_QUOTE;
          else if (!blank) nxt = ST_ARG;
        end
        ST_LABEL: begin
          if (c == CH_SLASH) nxt = ST_SLASH;
          else if (!blank) nxt = ST_HEAD;
          else nxt = ST_IDLE;
        end
        ST_EQ, ST_COMMA: begin
          if (!blank) nxt = ST_ARG;
        end
        ST_ARG: begin
          if (c == CH_SEMI || blank) nxt = ST_IDLE;
          else if (c == CH_COMMA) nxt = ST_COMMA;
        end
        ST_SLASH: begin
          if (c == CH_SLASH) begin
            nxt = ST_REMARK;
          end else begin
            nxt = ST_IDLE;
            raise_error(ERR_SLASH);
          end
        end
        ST_REMARK: begin
          if (c == CH_LF) nxt = ST_IDLE;
        end
        ST_QUOTE: begin
          if (c == CH_BSLASH) nxt = ST_BACKSL;
          else if (c == CH_QUOTE) nxt = ST_IDLE;
        end
        ST_BACKSL: begin
          nxt = ST_QUOTE;
        end
        default: ;
      endcase

      // buffer and event work of the state entered
      case (nxt)
        ST_IDLE: flush_line();
        ST_HEAD, ST_ARG: begin
          if (prev != nxt) open_token();
          push_char(c);
        end
        ST_GAP: push_char(CH_NUL);
        ST_LABEL: begin
          push_char(CH_NUL);
          close_line(LK_LABEL);
        end
        ST_EQ: begin
          push_char(CH_NUL);
          pend_kind = LK_DEFINE;
        end
        ST_COMMA: begin
          if (prev != ST_COMMA) push_char(CH_NUL);
        end
        ST_QUOTE: begin
          if (prev == ST_BACKSL) begin
            // unknown escapes write nothing
            case (c)
              CH_QUOTE:  push_char(CH_QUOTE);
              CH_BSLASH: push_char(CH_BSLASH);
              CH_LOW_N:  push_char(CH_LF);
              CH_LOW_T:  push_char(CH_TAB);
              default: ;
            endcase
          end else if (prev != ST_QUOTE) begin
            open_token();
          end else begin
            push_char(c);
          end
        end
        default: ;
      endcase
      lex_state = nxt;
    end

    if (byte_events.size() != 0) byte_events[byte_events.size()-1].last = 1'b1;
    foreach (byte_events[i]) events_due.push_back(byte_events[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_event();
    lex_event_t want;
    if (events_due.size() == 0) begin
      $error("event with nothing expected: kind %0d value %0d", event_kind_i,
             event_value_i);
      fails++;
    end else begin
      want = events_due.pop_front();
      seen++;
      if (want.ev.kind == EV_ERROR) lex_errors++;
      check_field("event_kind", 32'(want.ev.kind), 32'(event_kind_i));
      check_field("event_value", 32'(want.ev.value), 32'(event_value_i));
      check_field("token_offset", 32'(want.ev.offset), 32'(token_offset_i));
      check_field("token_total", 32'(want.ev.total), 32'(token_total_i));
      check_field("line_kind", 32'(want.ev.lkind), 32'(line_kind_i));
      check_field("line_cnt", 32'(want.line), 32'(line_cnt_i));
      check_field("last_of_run", 32'(want.last), 32'(last_of_run_i));
    end
  endtask

  // compare leaving events first, then model the byte taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_state  = ST_IDLE;
      fill       = '0;
      tokens     = '0;
      pend_kind  = LK_INSTR;
      line_count = LINE_W'(1);
      events_due.delete();
      fails      = 0;
      seen       = 0;
      lex_errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_event();
      if (in_valid_i && !in_stall_i) lex_byte(char_code_i, end_of_input_i);
    end
    fail_count_o <= fails;
    pending_o    <= events_due.size();
    events_o     <= seen;
    errors_o     <= lex_errors;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assembly source tokenizer testbench
// Feeds the tokenizer hand-picked lines and a stream of random well-formed
// and broken source lines, with random gaps on both channels and one long
// event back-pressure, then closes the source. The event checker predicts
// and compares every event.
// ----------------------------------------------------------------------------

module tb_top;
  import asmtok_pkg::*;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 260;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef enum {
    SHAPE_INSTR,
    SHAPE_LABEL,
    SHAPE_DEFINE,
    SHAPE_STRING,
    SHAPE_REMARK,
    SHAPE_NOISE,
    SHAPE_BROKEN
  } shape_e;

  typedef enum {
    TAIL_SLASH,
    TAIL_DEFINE,
    TAIL_WORD
  } tail_e;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                src_valid = 1'b0;
  logic                src_stall;
  logic [7:0]          src_char = 8'd0;
  logic                src_end  = 1'b0;
  logic                ev_valid;
  logic                ev_stall = 1'b0;
  logic [1:0]          ev_kind;
  logic [7:0]          ev_value;
  logic [OFFSET_W-1:0] ev_offset;
  logic [TOTAL_W-1:0]  ev_total;
  logic [1:0]          ev_lkind;
  logic [LINE_W-1:0]   ev_line;
  logic                ev_last;

  int fail_count;
  int pending;
  int events_checked;
  int error_events;

  // source bytes of the line being built
  logic [7:0] line_text[$];
  int         bytes_sent = 0;
  int         calm_left  = 0;
  logic       hold_req   = 1'b0;

  always #2 clk_i = ~clk_i;

  assembly_source_tokenizer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (src_valid),
    .in_stall_o     (src_stall),
    .char_code_i    (src_char),
    .end_of_input_i (src_end),
    .out_valid_o    (ev_valid),
    .out_stall_i    (ev_stall),
    .event_kind_o   (ev_kind),
    .event_value_o  (ev_value),
    .token_offset_o (ev_offset),
    .token_total_o  (ev_total),
    .line_kind_o    (ev_lkind),
    .line_cnt_o     (ev_line),
    .last_of_run_o  (ev_last)
  );

  asmtok_event_checker event_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (src_valid),
    .in_stall_i     (src_stall),
    .char_code_i    (src_char),
    .end_of_input_i (src_end),
    .out_valid_i    (ev_valid),
    .out_stall_i    (ev_stall),
    .event_kind_i   (ev_kind),
    .event_value_i  (ev_value),
    .token_offset_i (ev_offset),
    .token_total_i  (ev_total),
    .line_kind_i    (ev_lkind),
    .line_cnt_i     (ev_line),
    .last_of_run_i  (ev_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .events_o       (events_checked),
    .errors_o       (error_events)
  );

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 8) return 8'($urandom_range(8'h30, 8'h39));
    if (r == 8) return 8'h5F;
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(5);
    if (r < 4) return CH_SPACE;
    if (r == 4) return CH_TAB;
    return CH_CR;
  endfunction

  task automatic add_name(input int unsigned n);
    repeat (n) line_text.push_back(name_char());
  endtask

  // offer one item from a falling edge, hold it until taken
  task automatic send_char(input logic [7:0] c, input logic fin);
    int unsigned gap;
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      r = $urandom_range(99);
      if (r < 3) calm_left = $urandom_range(20, 60);
      gap = (r < 65) ? 0 : idle_len();
    end
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    src_valid <= 1'b1;
    src_char  <= c;
    src_end   <= fin;
    do @(posedge clk_i); while (src_stall);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (line_text[i]) send_char(line_text[i], 1'b0);
    line_text.delete();
  endtask

  // event sink: runs of stall and no stall, plus one long hold-off on request
  initial begin : event_sink
    int unsigned run_left;
    logic        stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        if (hold_req) begin
          hold_req  = 1'b0;
          stall_now = 1'b1;
          run_left  = HOLD_CYCLES;
        end else if ($urandom_range(99) < 35) begin
          stall_now = 1'b1;
          run_left  = idle_len();
        end else begin
          stall_now = 1'b0;
          run_left  = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
        end
      end
      run_left--;
      ev_stall <= stall_now;
    end
  end

  // watchdog on cycles where neither channel moves an item
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((src_valid && !src_stall) || (ev_valid && !ev_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d cycles with no item moving", WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned n;
    int unsigned stop_at;
    shape_e      shape;
    tail_e       tail;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // label named by byte 0xFF
    line_text = '{8'hFF, CH_COLON, CH_LF};
    send_text();
    // NUL mnemonic, repeated gap separators, doubled comma
    line_text = '{CH_NUL, CH_SPACE, CH_CR, "a", CH_COMMA, CH_COMMA, "b", CH_SEMI};
    send_text();
    // define with repeated separators after the equal sign
    line_text = '{"x", CH_EQUAL, CH_SPACE, CH_TAB, "1", CH_LF};
    send_text();
    // string with a newline escape, an unknown escape and an escaped quote
    line_text = '{"p", CH_SPACE, CH_QUOTE, CH_BSLASH, CH_LOW_N, CH_BSLASH, "q",
                  CH_BSLASH, CH_QUOTE, CH_QUOTE};
    send_text();
    // comment, then a lone slash that swallows the next byte
    line_text = '{CH_SLASH, CH_SLASH, "z", CH_LF, CH_SLASH, "a"};
    send_text();

    // event side held off for a long stretch early in the random stream
    hold_req = 1'b1;

    // random lines, mostly well formed
    stop_at = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 35) shape = SHAPE_INSTR;
      else if (r < 47) shape = SHAPE_LABEL;
      else if (r < 59) shape = SHAPE_DEFINE;
      else if (r < 72) shape = SHAPE_STRING;
      else if (r < 80) shape = SHAPE_REMARK;
      else if (r < 90) shape = SHAPE_NOISE;
      else shape = SHAPE_BROKEN;

      case (shape)
        SHAPE_INSTR: begin
          if ($urandom_range(3) == 0) line_text.push_back(blank_char());
          add_name($urandom_range(1, 5));
          n = ($urandom_range(5) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
          if (n != 0) begin
            line_text.push_back(blank_char());
            if ($urandom_range(4) == 0) line_text.push_back(blank_char());
          end
          for (int k = 0; k < n; k++) begin
            if (k != 0) begin
              line_text.push_back(CH_COMMA);
              if ($urandom_range(3) == 0) line_text.push_back(blank_char());
              else if ($urandom_range(5) == 0) line_text.push_back(CH_COMMA);
            end
            add_name($urandom_range(1, 4));
          end
          r = $urandom_range(3);
          if (r == 1 || r == 2) line_text.push_back(CH_SEMI);
          if (r == 2) begin
            line_text.push_back(CH_SLASH);
            line_text.push_back(CH_SLASH);
            add_name($urandom_range(0, 5));
          end
          if (r == 3) line_text.push_back(CH_CR);
          line_text.push_back(CH_LF);
        end
        SHAPE_LABEL: begin
          add_name($urandom_range(1, 6));
          line_text.push_back(CH_COLON);
          line_text.push_back(($urandom_range(1) == 0) ? CH_LF : blank_char());
        end
        SHAPE_DEFINE: begin
          add_name($urandom_range(1, 6));
          if ($urandom_range(1) == 0) line_text.push_back(blank_char());
          line_text.push_back(CH_EQUAL);
          repeat ($urandom_range(0, 2)) line_text.push_back(blank_char());
          add_name($urandom_range(1, 4));
          line_text.push_back(($urandom_range(1) == 0) ? CH_LF : CH_SEMI);
        end
        SHAPE_STRING: begin
          add_name($urandom_range(1, 4));
          line_text.push_back(blank_char());
          line_text.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(9);
            if (r < 5) begin
              line_text.push_back(name_char());
            end else if (r == 5) begin
              line_text.push_back(blank_char());
            end else begin
              line_text.push_back(CH_BSLASH);
              case ($urandom_range(4))
                0: line_text.push_back(CH_QUOTE);
                1: line_text.push_back(CH_BSLASH);
                2: line_text.push_back(CH_LOW_N);
                3: line_text.push_back(CH_LOW_T);
                default: line_text.push_back(name_char());
              endcase
            end
          end
          line_text.push_back(CH_QUOTE);
          line_text.push_back(CH_LF);
        end
        SHAPE_REMARK: begin
          line_text.push_back(CH_SLASH);
          line_text.push_back(CH_SLASH);
          repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(255);
            line_text.push_back((r == CH_LF) ? CH_SPACE : 8'(r));
          end
          line_text.push_back(CH_LF);
        end
        SHAPE_NOISE: begin
          repeat ($urandom_range(1, 12)) line_text.push_back(8'($urandom_range(255)));
        end
        default: begin
          // lone slash, or an operand list cut short after its commas
          if ($urandom_range(1) == 0) begin
            line_text.push_back(CH_SLASH);
            line_text.push_back(8'($urandom_range(255)));
          end else begin
            add_name($urandom_range(1, 3));
            line_text.push_back(CH_SPACE);
            add_name($urandom_range(1, 3));
            line_text.push_back(CH_COMMA);
            line_text.push_back(CH_COMMA);
            line_text.push_back(CH_LF);
          end
        end
      endcase
      send_text();
    end

    // close the source in the middle of something, then bytes that are ignored
    line_text.push_back(CH_LF);
    tail = tail_e'($urandom_range(2));
    case (tail)
      TAIL_SLASH: line_text.push_back(CH_SLASH);
      TAIL_DEFINE: line_text = '{CH_LF, "k", CH_EQUAL, "7"};
      default: line_text = '{CH_LF, "o", "p"};
    endcase
    send_text();
    send_char(8'($urandom_range(255)), 1'b1);
    repeat (4) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    src_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d source bytes, with one event hold-off of %0d cycles",
             bytes_sent, HOLD_CYCLES);
    $display("checked %0d events, %0d of them lexer errors", events_checked,
             error_events);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
